// File: rtl/core/i64dm_pkg.sv
// Shared types and constants for the 64-bit integer divide and modulo unit.
`timescale 1ns / 1ps

package i64dm_pkg;

   // Operand and result width, and the step counter that walks its bits.
   localparam int WORD_W = 64;
   localparam int STEP_W = $clog2(WORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [1:0]        cmd_type;

   // Operation codes carried by the cmd field of a request.
   localparam cmd_type CMD_UDIV = 2'd0;
   localparam cmd_type CMD_UREM = 2'd1;
   localparam cmd_type CMD_SDIV = 2'd2;
   localparam cmd_type CMD_SREM = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request operands
      logic prep;    // take the magnitudes of signed operands
      logic step;    // retire one quotient bit
      logic finish;  // apply the sign and load the output register
   } dp_ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_by_zero;
   } dp_stat_type;

endpackage

// File: rtl/core/i64dm_req_if.sv
// Request channel: operation code and the two operands.
`timescale 1ns / 1ps

interface i64dm_req_if;
   import i64dm_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  cmd;
   word_type dividend;
   word_type divisor;

   modport source (output valid, output cmd, output dividend, output divisor, input ready);
   modport sink   (input valid, input cmd, input dividend, input divisor, output ready);
endinterface

// File: rtl/core/i64dm_rsp_if.sv
// Response channel: quotient or remainder and the zero divisor flag.
`timescale 1ns / 1ps

interface i64dm_rsp_if;
   import i64dm_pkg::*;

   logic     valid;
   logic     ready;
   word_type result;
   logic     div_by_zero;

   modport source (output valid, output result, output div_by_zero, input ready);
   modport sink   (input valid, input result, input div_by_zero, output ready);
endinterface

// File: rtl/core/int64_divide_modulo.sv
// Top level of the 64-bit integer divide and modulo unit.
`timescale 1ns / 1ps

// Divides a 64-bit dividend by a 64-bit divisor and returns the unsigned
// quotient, unsigned remainder, signed quotient or signed remainder, as the
// request's cmd selects. Signed quotients truncate toward zero and a signed
// remainder takes the sign of the dividend; the most negative value is its own
// negation. A zero divisor returns 0 with div_by_zero set. One request is
// worked on at a time: after acceptance a prep state takes the operand
// magnitudes, the radix-2 restoring loop retires one quotient bit per cycle
// for 64 steps, and a finish state applies the sign and loads the output
// register; the unit then returns to idle and can take the next request. A
// zero divisor skips the loop. The loop of 64 dependent subtractions through
// the shared 65-bit subtractor sets the time to a result. A finished result
// waits in the output register while the next request is accepted and
// divided; the final sign step of that next request waits for as long as
// the output register still holds an undrained result.
module int64_divide_modulo (
   input logic             clock,
   input logic             reset,
   i64dm_req_if.sink       req,
   i64dm_rsp_if.source     rsp
);
   import i64dm_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // Sequencer.
   i64dm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   // Operand registers, divider step and output register.
   i64dm_datapath u_datapath (
      .clock           (clock),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_cmd         (req.cmd),
      .req_dividend    (req.dividend),
      .req_divisor     (req.divisor),
      .rsp_result      (rsp.result),
      .rsp_div_by_zero (rsp.div_by_zero)
   );

   // Only one request is in flight: ready drops right after an acceptance.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while another is in progress");

   // A zero divisor never reaches the subtraction loop.
   a_no_step_on_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> !stat.div_by_zero)
      else $error("divider stepping with a zero divisor");

   // A zero divisor response always carries a zero result.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.div_by_zero) |-> (rsp.result == '0))
      else $error("non-zero result for a zero divisor");

endmodule

// File: rtl/core/i64dm_datapath.sv
// Datapath of the divider: operand registers, restoring step and sign fix-up.
`timescale 1ns / 1ps

module i64dm_datapath (
   input  logic                  clock,
   input  i64dm_pkg::dp_ctrl_type ctrl,
   output i64dm_pkg::dp_stat_type stat,
   input  i64dm_pkg::cmd_type    req_cmd,
   input  i64dm_pkg::word_type   req_dividend,
   input  i64dm_pkg::word_type   req_divisor,
   output i64dm_pkg::word_type   rsp_result,
   output logic                  rsp_div_by_zero
);
   import i64dm_pkg::*;

   cmd_type  cmd_ff, cmd_in;
   word_type num_ff, num_in;   // dividend, then quotient bits shift in at the bottom
   word_type den_ff, den_in;
   word_type rem_ff, rem_in;
   logic     a_neg_ff, a_neg_in;
   logic     b_neg_ff, b_neg_in;
   logic     dbz_ff, dbz_in;
   word_type result_ff, result_in;
   logic     rsp_dbz_ff, rsp_dbz_in;

   logic         is_signed;
   logic         want_rem;
   logic         carry;
   word_type     rem_shift;
   logic [WORD_W:0] diff;
   logic         take;
   word_type     fixed_quo;
   word_type     fixed_rem;

   // Decode the operation.
   always_comb begin
      is_signed = cmd_ff inside {CMD_SDIV, CMD_SREM};
      want_rem  = cmd_ff inside {CMD_UREM, CMD_SREM};
   end

   // One restoring step: shift in the next dividend bit and try the subtraction.
   // A bit shifted out of the remainder means it is certainly above the divisor.
   always_comb begin
      carry     = rem_ff[WORD_W-1];
      rem_shift = {rem_ff[WORD_W-2:0], num_ff[WORD_W-1]};
      diff      = {1'b0, rem_shift} - {1'b0, den_ff};
      take      = carry | ~diff[WORD_W];
   end

   // Sign fix-up of the quotient and remainder.
   always_comb begin
      fixed_quo = (is_signed && (a_neg_ff != b_neg_ff)) ? (~num_ff + 1'b1) : num_ff;
      fixed_rem = (is_signed && a_neg_ff) ? (~rem_ff + 1'b1) : rem_ff;
   end

   // Next values of the working registers.
   always_comb begin
      cmd_in     = cmd_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      a_neg_in   = a_neg_ff;
      b_neg_in   = b_neg_ff;
      dbz_in     = dbz_ff;
      result_in  = result_ff;
      rsp_dbz_in = rsp_dbz_ff;
      if (ctrl.load) begin
         cmd_in = req_cmd;
         num_in = req_dividend;
         den_in = req_divisor;
         dbz_in = (req_divisor == '0);
      end
      if (ctrl.prep) begin
         a_neg_in = is_signed & num_ff[WORD_W-1];
         b_neg_in = is_signed & den_ff[WORD_W-1];
         num_in   = (is_signed && num_ff[WORD_W-1]) ? (~num_ff + 1'b1) : num_ff;
         den_in   = (is_signed && den_ff[WORD_W-1]) ? (~den_ff + 1'b1) : den_ff;
         rem_in   = '0;
      end
      if (ctrl.step) begin
         rem_in = take ? diff[WORD_W-1:0] : rem_shift;
         num_in = {num_ff[WORD_W-2:0], take};
      end
      if (ctrl.finish) begin
         rsp_dbz_in = dbz_ff;
         if (dbz_ff) begin
            result_in = '0;
         end else if (want_rem) begin
            result_in = fixed_rem;
         end else begin
            result_in = fixed_quo;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      a_neg_ff   <= a_neg_in;
      b_neg_ff   <= b_neg_in;
      dbz_ff     <= dbz_in;
      result_ff  <= result_in;
      rsp_dbz_ff <= rsp_dbz_in;
   end

   assign stat.div_by_zero = dbz_ff;
   assign rsp_result       = result_ff;
   assign rsp_div_by_zero  = rsp_dbz_ff;

endmodule

// File: rtl/core/i64dm_control.sv
// Controller of the divider: sequences load, sign handling, 64 steps and output.
`timescale 1ns / 1ps

module i64dm_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output i64dm_pkg::dp_ctrl_type ctrl,
   input  i64dm_pkg::dp_stat_type stat
);
   import i64dm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Next state and commands to the datapath.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      ctrl         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            ctrl.prep = 1'b1;
            count_in  = '0;
            state_in  = stat.div_by_zero ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            ctrl.step = 1'b1;
            count_in  = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.finish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, step counter and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: tb/int64_divide_modulo_tb.sv
// Self-checking testbench for the 64-bit integer divide and modulo unit.
`timescale 1ns / 1ps

module int64_divide_modulo_tb;
   import i64dm_pkg::*;

   // Cycles with no request or result accepted before the run is abandoned.
   localparam int STALL_LIMIT = 1000;
   // Cycles to wait after the last expected result for any stray result.
   localparam int SETTLE_CYCLES = 100;

   localparam word_type ALL_ONES = {WORD_W{1'b1}};
   localparam word_type MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(WORD_W-1){1'b1}}};

   // One expected result: quotient or remainder and the zero divisor flag.
   typedef struct packed {
      word_type result;
      logic     div_by_zero;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic no_idle;
   int   mismatch_count;
   int   idle_cycles;

   answer_type expected_answers[$];

   i64dm_req_if req_ch ();
   i64dm_rsp_if rsp_ch ();

   int64_divide_modulo u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Divides the magnitudes without sign, then applies the sign rules of the chosen
   // operation. Negation wraps, so the most negative value stays as it is.
   function automatic answer_type divide_predict(cmd_type cmd, word_type a, word_type b);
      answer_type ans;
      logic       signed_op;
      logic       a_neg;
      logic       b_neg;
      word_type   mag_a;
      word_type   mag_b;
      word_type   quo;
      word_type   rem;
      ans.div_by_zero = (b == '0);
      ans.result      = '0;
      if (ans.div_by_zero) begin
         return ans;
      end
      signed_op = (cmd == CMD_SDIV) || (cmd == CMD_SREM);
      a_neg     = signed_op && a[WORD_W-1];
      b_neg     = signed_op && b[WORD_W-1];
      mag_a     = a_neg ? -a : a;
      mag_b     = b_neg ? -b : b;
      quo       = mag_a / mag_b;
      rem       = mag_a % mag_b;
      case (cmd)
         CMD_UDIV: ans.result = quo;
         CMD_UREM: ans.result = rem;
         CMD_SDIV: ans.result = (a_neg != b_neg) ? -quo : quo;
         default:  ans.result = a_neg ? -rem : rem;
      endcase
      return ans;
   endfunction

   // Operand shapes: full width, tiny, edge values, random magnitude,
   // small negatives and powers of two or one less.
   function automatic word_type pick_operand();
      word_type v;
      case ($urandom_range(5))
         0: v = {$urandom, $urandom};
         1: v = word_type'($urandom_range(16));
         2: begin
            case ($urandom_range(5))
               0: v = '0;
               1: v = word_type'(1);
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               4: v = MOST_POS;
               default: v = MOST_NEG + word_type'(1);
            endcase
         end
         3: v = {$urandom, $urandom} >> $urandom_range(WORD_W - 1);
         4: v = -word_type'($urandom_range(1, 16));
         default: begin
            v = word_type'(1) << $urandom_range(WORD_W - 1);
            if ($urandom_range(1) == 1) begin
               v = v - word_type'(1);
            end
         end
      endcase
      return v;
   endfunction

   function automatic cmd_type pick_cmd();
      case ($urandom_range(3))
         0: return CMD_UDIV;
         1: return CMD_UREM;
         2: return CMD_SDIV;
         default: return CMD_SREM;
      endcase
   endfunction

   // Sends one request, with a random gap before it, and records the expected
   // result once it is accepted. Returns at the accepting clock edge.
   task automatic send_request(cmd_type cmd, word_type dividend, word_type divisor);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.dividend <= dividend;
      req_ch.divisor  <= divisor;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      expected_answers.push_back(divide_predict(cmd, dividend, divisor));
   endtask

   // Withdraws the request and waits until every expected result has arrived.
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         send_request(pick_cmd(), pick_operand(), pick_operand());
      end
   endtask

   // Sign combinations, zero divisors, the most negative value and divisors
   // with the top bit set.
   task automatic test_directed_cases();
      send_request(CMD_UDIV, word_type'(100), word_type'(7));
      send_request(CMD_UREM, word_type'(100), word_type'(7));
      send_request(CMD_SDIV, -word_type'(100), word_type'(7));
      send_request(CMD_SREM, -word_type'(100), word_type'(7));
      send_request(CMD_SDIV, word_type'(100), -word_type'(7));
      send_request(CMD_SREM, word_type'(100), -word_type'(7));
      send_request(CMD_SDIV, -word_type'(100), -word_type'(7));
      send_request(CMD_UDIV, ALL_ONES, '0);
      send_request(CMD_UREM, MOST_NEG, '0);
      send_request(CMD_SDIV, MOST_POS, '0);
      send_request(CMD_SREM, '0, '0);
      send_request(CMD_SDIV, MOST_NEG, ALL_ONES);
      send_request(CMD_SREM, MOST_NEG, ALL_ONES);
      send_request(CMD_SDIV, MOST_NEG, word_type'(1));
      send_request(CMD_UDIV, MOST_NEG, ALL_ONES);
      send_request(CMD_UREM, ALL_ONES, MOST_NEG);
      send_request(CMD_UDIV, ALL_ONES, MOST_NEG + word_type'(1));
      send_request(CMD_UDIV, ALL_ONES, word_type'(1));
      send_request(CMD_UREM, '0, ALL_ONES);
      send_request(CMD_SDIV, MOST_POS, MOST_NEG);
      send_request(CMD_SREM, MOST_NEG, MOST_NEG);
      send_request(CMD_UREM, word_type'(5), ALL_ONES);
   endtask

   // The sender stops until the unit has returned everything.
   task automatic test_drain_pause();
      send_random(20);
      wait_for_drain();
      send_random(20);
   endtask

   // A long stretch in which neither side idles.
   task automatic test_back_to_back();
      no_idle = 1'b1;
      send_random(250);
      no_idle = 1'b0;
   endtask

   task automatic test_random_operands();
      send_random(1000);
   endtask

   // Result ready: idles at random unless idling is switched off.
   always @(negedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 24);
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual result %h div_by_zero %b",
                     $time, rsp_ch.result, rsp_ch.div_by_zero);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_ch.result !== want.result) begin
               mismatch_count++;
               $display("%0t: result mismatch, expected %h, actual %h",
                        $time, want.result, rsp_ch.result);
            end
            if (rsp_ch.div_by_zero !== want.div_by_zero) begin
               mismatch_count++;
               $display("%0t: div_by_zero mismatch, expected %b, actual %b",
                        $time, want.div_by_zero, rsp_ch.div_by_zero);
            end
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Reset, the tests in turn, then the final verdict.
   initial begin
      reset           = 1'b1;
      no_idle         = 1'b0;
      mismatch_count  = 0;
      idle_cycles     = 0;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_UDIV;
      req_ch.dividend = '0;
      req_ch.divisor  = '0;
      rsp_ch.ready    = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_drain_pause();
      test_back_to_back();
      test_random_operands();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/i64dm_pkg.sv
rtl/core/i64dm_req_if.sv
rtl/core/i64dm_rsp_if.sv
rtl/core/i64dm_datapath.sv
rtl/core/i64dm_control.sv
rtl/core/int64_divide_modulo.sv
tb/int64_divide_modulo_tb.sv
